// File: rtl/text_console_character_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Text console engine assertion macros
// Shared property shapes for the checker of the text console engine.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcce same-cycle check failed");

// next-cycle implication
`define TCCE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcce next-cycle check failed");

`endif

// File: rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console engine package
// Command codes, character codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcce_pkg;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } tcce_op_type;

   localparam logic [7:0] CH_BLANK     = 8'h20;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] ATTR_RESET   = 8'h0F;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_FILL,
      ST_RESP
   } tcce_state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic cnt_clear;
      logic cnt_inc;
      logic copy_step;
      logic fill_step;
      logic fill_reset;
      logic rsp_load;
   } tcce_cmd_type;

   typedef struct packed {
      tcce_op_type op;
      logic        scroll_need;
      logic        copy_last;
      logic        fill_last;
      logic        rsp_free;
   } tcce_status_type;

endpackage

// File: rtl/text_console_character_engine_unit.sv
// ----------------------------------------------------------------------------
// Text console character engine
// Character-cell console with cursor, wrap, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one command per item (put character, clear, read cell);
//   rsp channel returns one item per command: cursor index, read cell, scroll flag.
//   csr_wr_en / csr_wr_data load the text attribute used for new cells.
// Steps from accept to result, with rsp_tready high:
//   put character without scroll, unused command: execute, then result load
//   read cell: execute with one registered store read, then result load
//   put character with scroll: execute, copy rows up by one row, blank bottom row
//   clear: execute, then blank every cell of the store
// One item is in work at a time, and the next is taken the cycle after its
// result is loaded; the cell-by-cell store walk sets the cost of scroll and
// clear. A result left waiting in the output register does not block
// acceptance of the next item, only its completion.
// Reset: cursor goes home, attribute returns to 0x0F, and the store is blanked
// to 0x0F20 one cell per cycle with req_tready low; attribute writes are taken
// during that pass.
// ----------------------------------------------------------------------------
module text_console_character_engine_unit import tcce_pkg::*; #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int TAB_STOP       = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], cell_index[18:8], zero[23:19]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // cursor_index[10:0], cell_value[26:11],
                                    // scrolled[27], zero[31:28]
);

   tcce_cmd_type    cmd;
   tcce_status_type status;

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcce_dp #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .TAB_STOP       (TAB_STOP)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_op      (req_tuser),
      .req_code    (req_tdata[7:0]),
      .req_index   (req_tdata[18:8]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// File: rtl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// Text console engine controller
// Sequences accept, execute, scroll copy, fill passes and result hand-off.
// ----------------------------------------------------------------------------
module tcce_ctrl import tcce_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  tcce_status_type status,
   output tcce_cmd_type    cmd
);

   tcce_state_type state_ff;
   tcce_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // power-up blanking of the whole store
            cmd.fill_step  = 1'b1;
            cmd.fill_reset = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (status.op)
               OP_CLEAR: begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = ST_FILL;
               end
               OP_READ: begin
                  state_in = ST_RESP;
               end
               default: begin
                  if (status.op == OP_PUT && status.scroll_need) begin
                     cmd.cnt_clear = 1'b1;
                     state_in      = ST_COPY;
                  end else if (status.rsp_free) begin
                     cmd.rsp_load = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            endcase
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            // hold the count at the bottom row start for the fill
            if (status.copy_last) begin
               state_in = ST_FILL;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (status.fill_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

// File: rtl/tcce_dp.sv
// ----------------------------------------------------------------------------
// Text console engine datapath
// Screen store, cursor, attribute register, pass counter and result register.
// ----------------------------------------------------------------------------
module tcce_dp import tcce_pkg::*; #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int TAB_STOP       = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data,
   input  logic [1:0]      req_op,
   input  logic [7:0]      req_code,
   input  logic [10:0]     req_index,
   input  tcce_cmd_type    cmd,
   output tcce_status_type status,
   input  logic            rsp_tready,
   output logic            rsp_tvalid,
   output logic [31:0]     rsp_tdata
);

   localparam int CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W   = $clog2(SCREEN_ROWS);
   localparam int NCOL_W  = $clog2(SCREEN_COLUMNS + TAB_STOP);
   localparam int NROW_W  = $clog2(SCREEN_ROWS + 1);
   localparam int COPY_N  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COPY_N);
   localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(CELLS - 1);
   localparam logic [12:0]       CELLS_13  = 13'(CELLS);
   localparam logic [NCOL_W-1:0] COLS_N    = NCOL_W'(SCREEN_COLUMNS);
   localparam logic [NROW_W-1:0] ROWS_N    = NROW_W'(SCREEN_ROWS);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);

   // item registers
   tcce_op_type       op_ff;
   logic [7:0]        code_ff;
   logic [10:0]       idx_ff;

   logic [7:0]        attr_ff;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic              scroll_ff;
   logic              scroll_in;
   logic              in_range_ff;
   logic              in_range_in;
   logic [ADDR_W-1:0] cnt_ff;
   logic [ADDR_W-1:0] cnt_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [31:0]       rsp_data_ff;

   logic [15:0]       screen_mem [CELLS];
   logic [15:0]       rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   logic [NCOL_W-1:0] tab_next [SCREEN_COLUMNS];

   logic              is_bs;
   logic              is_tab;
   logic              is_cr;
   logic              is_lf;
   logic              is_print;
   logic [COL_W-1:0]  col_dec;
   logic [NCOL_W-1:0] col_a;
   logic [NROW_W-1:0] row_a;
   logic [NROW_W-1:0] row_b;
   logic              wrap;
   logic              scroll_now;
   logic [COL_W-1:0]  col_put;
   logic [ROW_W-1:0]  row_put;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] next_addr;
   logic [15:0]       blank;
   logic [15:0]       cell_val;
   logic              exec_put;

   for (genvar g = 0; g < SCREEN_COLUMNS; g++) begin : g_tab
      assign tab_next[g] = NCOL_W'((g / TAB_STOP + 1) * TAB_STOP);
   end

   assign blank    = {attr_ff, CH_BLANK};
   assign exec_put = cmd.exec && (op_ff == OP_PUT);

   // character decode
   assign is_bs    = (code_ff == CH_BACKSPACE);
   assign is_tab   = (code_ff == CH_TAB);
   assign is_cr    = (code_ff == CH_RETURN);
   assign is_lf    = (code_ff == CH_NEWLINE);
   assign is_print = (code_ff >= CH_BLANK);
   assign col_dec  = (col_ff == '0) ? col_ff : COL_W'(col_ff - 1'b1);

   always_comb begin
      col_a = NCOL_W'(col_ff);
      row_a = NROW_W'(row_ff);
      if (is_bs) begin
         col_a = NCOL_W'(col_dec);
      end else if (is_tab) begin
         col_a = tab_next[col_ff];
      end else if (is_cr) begin
         col_a = '0;
      end else if (is_lf) begin
         col_a = '0;
         row_a = NROW_W'(row_ff) + 1'b1;
      end else if (is_print) begin
         col_a = NCOL_W'(col_ff) + 1'b1;
      end
   end

   assign wrap       = (col_a >= COLS_N);
   assign row_b      = wrap ? NROW_W'(row_a + 1'b1) : row_a;
   assign col_put    = wrap ? '0 : col_a[COL_W-1:0];
   assign scroll_now = (row_b >= ROWS_N);
   assign row_put    = scroll_now ? ROW_LAST : row_b[ROW_W-1:0];

   // cell under the cursor, after the backspace step
   assign cur_addr = ADDR_W'(row_ff) * COLS_A + ADDR_W'(is_bs ? col_dec : col_ff);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      scroll_in   = scroll_ff;
      in_range_in = in_range_ff;
      if (cmd.exec) begin
         scroll_in   = exec_put && scroll_now;
         in_range_in = ({2'b00, idx_ff} < CELLS_13);
         if (op_ff == OP_PUT) begin
            col_in = col_put;
            row_in = row_put;
         end else if (op_ff == OP_CLEAR) begin
            col_in = '0;
            row_in = '0;
         end
      end
   end

   assign next_addr = ADDR_W'(row_in) * COLS_A + ADDR_W'(col_in);

   // store ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = blank;
      if (exec_put && (is_bs || is_print)) begin
         mem_we    = 1'b1;
         mem_waddr = cur_addr;
         mem_wdata = is_bs ? blank : {attr_ff, code_ff};
      end else if (cmd.copy_step && (cnt_ff != '0)) begin
         // the write trails the read and stores the registered cell from one row down
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(cnt_ff - 1'b1);
         mem_wdata = rdata_ff;
      end else if (cmd.fill_step) begin
         mem_we    = 1'b1;
         mem_wdata = cmd.fill_reset ? {ATTR_RESET, CH_BLANK} : blank;
      end
   end

   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = ADDR_W'(idx_ff);
      if (cmd.exec && (op_ff == OP_READ)) begin
         mem_re = 1'b1;
      end else if (cmd.copy_step && !status.copy_last) begin
         mem_re    = 1'b1;
         mem_raddr = cnt_ff + COLS_A;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= screen_mem[mem_raddr];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = ADDR_W'(cnt_ff + 1'b1);
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_tready);
   assign cell_val     = ((op_ff == OP_READ) && in_range_ff) ? rdata_ff : 16'h0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         scroll_ff    <= 1'b0;
         in_range_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         scroll_ff    <= scroll_in;
         in_range_ff  <= in_range_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= tcce_op_type'(req_op);
         code_ff <= req_code;
         idx_ff  <= req_index;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {4'b0000, scroll_in, cell_val, 11'(next_addr)};
      end
   end

   assign status.op          = op_ff;
   assign status.scroll_need = scroll_now;
   assign status.copy_last   = (cnt_ff == COPY_LAST);
   assign status.fill_last   = (cnt_ff == FILL_LAST);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/tcce_checker.sv
// ----------------------------------------------------------------------------
// Text console engine checker
// Port-level checks on handshake and result consistency, bound to the top.
// ----------------------------------------------------------------------------
`include "text_console_character_engine_unit_macros.svh"

module tcce_checker #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   localparam logic [10:0] LAST_ROW_IDX = 11'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);

   `TCCE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TCCE_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `TCCE_ASSERT_NXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   `TCCE_ASSERT_IMP(a_scroll_home, clock, reset, rsp_tvalid && rsp_tdata[27], rsp_tdata[10:0] == LAST_ROW_IDX)
   `TCCE_ASSERT_IMP(a_scroll_no_cell, clock, reset, rsp_tvalid && rsp_tdata[27], rsp_tdata[26:11] == 16'h0000)

endmodule

bind text_console_character_engine_unit tcce_checker #(
   .SCREEN_COLUMNS (SCREEN_COLUMNS),
   .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console engine testbench
// Streams put-character, clear, read-cell and unused commands into the console,
// tracks its screen, cursor and attribute in a local mirror, and compares every
// result item field by field. The text attribute is changed between phases while
// the engine is idle, and both sides stall at random outside the last two phases.
// ----------------------------------------------------------------------------
module tb_top;
   import tcce_pkg::*;

   localparam int COLS        = 80;
   localparam int ROWS        = 25;
   localparam int TAB_WIDTH   = 8;
   localparam int CELLS       = COLS * ROWS;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_ITEMS = 265;

   typedef struct {
      tcce_op_type op;
      logic [7:0]  code;
      logic [10:0] idx;
   } console_item_type;

   typedef struct {
      logic [10:0] cursor_pos;
      logic [15:0] cell_word;
      logic        scroll_flag;
   } console_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'h0;   // char_code[7:0], cell_index[18:8], zero[23:19]
   logic [1:0]  req_tuser = 2'b00;   // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // cursor_index[10:0], cell_value[26:11],
                                     // scrolled[27], zero[31:28]

   // mirror of the console
   logic [15:0] screen_mirror [0:CELLS-1];
   int          cur_col;
   int          cur_row;
   logic [7:0]  text_attr;

   console_item_type   pend_items[$];
   console_result_type pending_results[$];
   console_item_type   held_item;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int scroll_count = 0;
   int clear_count = 0;
   int read_count = 0;
   int stall_cycles = 0;

   text_console_character_engine_unit #(
      .SCREEN_COLUMNS(COLS),
      .SCREEN_ROWS(ROWS),
      .TAB_STOP(TAB_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one command to the mirror and return the result it should give.
   function automatic console_result_type advance_console(console_item_type it);
      console_result_type res;
      logic [15:0]        blank;
      int                 i;
      int                 pos;
      blank = {text_attr, CH_BLANK};
      res.cell_word = 16'h0;
      res.scroll_flag = 1'b0;
      case (it.op)
         OP_PUT: begin
            if (it.code == CH_BACKSPACE) begin
               if (cur_col != 0) cur_col--;
               screen_mirror[cur_row * COLS + cur_col] = blank;
            end else if (it.code == CH_TAB) begin
               cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
            end else if (it.code == CH_RETURN) begin
               cur_col = 0;
            end else if (it.code == CH_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (it.code >= CH_BLANK) begin
               screen_mirror[cur_row * COLS + cur_col] = {text_attr, it.code};
               cur_col++;
            end
            if (cur_col >= COLS) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= ROWS) begin
               for (i = 0; i < (ROWS - 1) * COLS; i++)
                  screen_mirror[i] = screen_mirror[i + COLS];
               for (i = (ROWS - 1) * COLS; i < CELLS; i++)
                  screen_mirror[i] = blank;
               cur_row = ROWS - 1;
               res.scroll_flag = 1'b1;
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < CELLS; i++)
               screen_mirror[i] = blank;
            cur_col = 0;
            cur_row = 0;
         end
         OP_READ: begin
            if (it.idx < CELLS) res.cell_word = screen_mirror[it.idx];
         end
         default: ;
      endcase
      pos = cur_row * COLS + cur_col;
      res.cursor_pos = pos[10:0];
      return res;
   endfunction

   function automatic console_item_type random_item();
      console_item_type it;
      int r;
      int p;
      r = $urandom_range(0, 999);
      it.code = 8'($urandom_range(0, 255));
      it.idx = 11'($urandom_range(0, 2047));
      if (r < 5) begin
         it.op = OP_CLEAR;
      end else if (r < 25) begin
         it.op = OP_NONE;
      end else if (r < 165) begin
         it.op = OP_READ;
         if ($urandom_range(0, 99) >= 30) it.idx = 11'($urandom_range(0, CELLS - 1));
      end else begin
         it.op = OP_PUT;
         p = $urandom_range(0, 99);
         if (p < 70) it.code = 8'($urandom_range(32, 255));
         else if (p < 78) it.code = CH_NEWLINE;
         else if (p < 84) it.code = CH_BACKSPACE;
         else if (p < 89) it.code = CH_TAB;
         else if (p < 93) it.code = CH_RETURN;
         else it.code = 8'($urandom_range(0, 31));
      end
      return it;
   endfunction

   task automatic push_item(tcce_op_type op, logic [7:0] code, logic [10:0] idx);
      console_item_type it;
      it.op = op;
      it.code = code;
      it.idx = idx;
      pend_items.push_back(it);
   endtask

   task automatic wait_drained();
      while (pend_items.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: predict at acceptance, then load the next item or idle.
   always @(posedge clock) begin : drive_proc
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_results.push_back(advance_console(held_item));
            items_accepted++;
            if (held_item.op == OP_CLEAR) clear_count++;
            if (held_item.op == OP_READ) read_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pend_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               held_item = pend_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, held_item.idx, held_item.code};
               req_tuser <= held_item.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Result checker
   always @(posedge clock) begin : check_proc
      console_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item: tdata %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.scroll_flag) scroll_count++;
            if (rsp_tdata[10:0] !== want.cursor_pos || rsp_tdata[26:11] !== want.cell_word
                || rsp_tdata[27] !== want.scroll_flag) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d: expected cursor %0d cell %h scrolled %b, got cursor %0d cell %h scrolled %b",
                     results_checked, want.cursor_pos, want.cell_word, want.scroll_flag,
                     rsp_tdata[10:0], rsp_tdata[26:11], rsp_tdata[27]);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d items pending", STALL_LIMIT,
            pend_items.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus_proc
      logic [7:0] phase_attr [0:5];
      int         ph;
      int         k;
      int         n;
      for (k = 0; k < CELLS; k++)
         screen_mirror[k] = 16'h0F20;
      cur_col = 0;
      cur_row = 0;
      text_attr = ATTR_RESET;
      send_idle_pct = 10;
      recv_stall_pct = 65;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // hold off until the power-up blanking pass is done
      while (!req_tready) @(posedge clock);

      // directed part under the reset attribute
      push_item(OP_READ, 8'h00, 11'd0);
      push_item(OP_PUT, 8'h41, 11'd0);
      push_item(OP_PUT, 8'hFF, 11'd2047);
      push_item(OP_PUT, CH_BLANK, 11'd0);
      push_item(OP_PUT, 8'h7F, 11'd0);
      push_item(OP_PUT, 8'h00, 11'd0);
      push_item(OP_PUT, 8'h1F, 11'd0);
      push_item(OP_PUT, CH_TAB, 11'd0);
      push_item(OP_PUT, CH_RETURN, 11'd0);
      push_item(OP_PUT, CH_BACKSPACE, 11'd0);
      push_item(OP_READ, 8'h00, 11'd0);
      push_item(OP_PUT, 8'h42, 11'd0);
      push_item(OP_PUT, CH_BACKSPACE, 11'd0);
      push_item(OP_READ, 8'h00, 11'd0);
      push_item(OP_PUT, CH_NEWLINE, 11'd0);
      push_item(OP_PUT, CH_TAB, 11'd0);
      push_item(OP_PUT, CH_TAB, 11'd0);
      push_item(OP_READ, 8'hFF, 11'd1999);
      push_item(OP_READ, 8'h00, 11'd2000);
      push_item(OP_READ, 8'h00, 11'd2047);
      push_item(OP_NONE, 8'hFF, 11'd2047);
      push_item(OP_READ, 8'h00, 11'd1);
      push_item(OP_CLEAR, 8'h00, 11'd0);
      push_item(OP_READ, 8'h00, 11'd1);
      push_item(OP_PUT, 8'h80, 11'd0);
      wait_drained();

      phase_attr[0] = 8'h00;
      phase_attr[1] = 8'hFF;
      phase_attr[2] = 8'($urandom_range(0, 255));
      phase_attr[3] = 8'h4E;
      phase_attr[4] = 8'($urandom_range(0, 255));
      phase_attr[5] = ATTR_RESET;

      for (ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_idle_pct = 10;
            recv_stall_pct = 65;
         end else if (ph < 4) begin
            send_idle_pct = 65;
            recv_stall_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         // write the attribute while the engine is idle
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_wr_data <= phase_attr[ph];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         text_attr = phase_attr[ph];

         k = 0;
         while (k < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) == 0) begin
               // a long line of text to force a wrap at the right edge
               n = $urandom_range(81, 100);
               repeat (n) push_item(OP_PUT, 8'($urandom_range(32, 255)),
                  11'($urandom_range(0, 2047)));
               k += n;
            end else begin
               pend_items.push_back(random_item());
               k++;
            end
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("%0d commands accepted, %0d results checked", items_accepted, results_checked);
      $display("%0d scrolls, %0d clears, %0d cell reads over 7 attribute settings",
         scroll_count, clear_count, read_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
            pending_results.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_ctrl.sv
rtl/tcce_dp.sv
rtl/text_console_character_engine_unit.sv
rtl/tcce_checker.sv
tb/tb_top.sv
